[sv/cht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg - shared types and constants of the chained hash table
// field widths, request and result codes, default sizes
// ----------------------------------------------------------------------------
package cht_pkg;

   // default sizes
   localparam int NUM_BUCKETS_DEF      = 151;
   localparam int SLOTS_PER_BUCKET_DEF = 8;
   localparam int VALUE_WIDTH_DEF      = 32;

   // payload widths
   localparam int OP_W        = 2;
   localparam int KEY_W       = 31;
   localparam int IN_VALUE_W  = 32;
   localparam int OUT_VALUE_W = 32;
   localparam int STATUS_W    = 3;

   // request kinds, the unused code behaves as find
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED      = 3'd0,
      STAT_EXISTS        = 3'd1,
      STAT_FOUND         = 3'd2,
      STAT_NOT_FOUND     = 3'd3,
      STAT_REMOVED       = 3'd4,
      STAT_REMOVE_ABSENT = 3'd5,
      STAT_FULL          = 3'd6
   } status_type;

endpackage
`default_nettype wire

[sv/cht_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_if - request and result channels of the chained hash table
// valid/ready channels, a transfer happens when both are high
// ----------------------------------------------------------------------------
interface cht_req_if;
   logic                          valid;
   logic                          ready;
   logic [cht_pkg::OP_W-1:0]       op;
   logic [cht_pkg::KEY_W-1:0]      key;
   logic [cht_pkg::IN_VALUE_W-1:0] write_value;

   modport source (output valid, output op, output key, output write_value, input ready);
   modport sink   (input valid, input op, input key, input write_value, output ready);
endinterface

interface cht_rsp_if;
   logic                           valid;
   logic                           ready;
   cht_pkg::status_type            status;
   logic [cht_pkg::OUT_VALUE_W-1:0] read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink   (input valid, input status, input read_value, output ready);
endinterface
`default_nettype wire

[sv/chained_hash_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table - key/value table with bounded per-bucket chains
// flow: a request passes the multiply, reduce and compare states to the
//   output register; a two-step multiply forms key mod NUM_BUCKETS, the
//   bucket row is registered in reduce, and a new request waits for idle
// reset: synchronous; afterwards a clearing pass writes every bucket row
//   (NUM_BUCKETS rows, 151 by default) while req.ready stays low
// ----------------------------------------------------------------------------
module chained_hash_table #(
   parameter int NUM_BUCKETS      = cht_pkg::NUM_BUCKETS_DEF,
   parameter int SLOTS_PER_BUCKET = cht_pkg::SLOTS_PER_BUCKET_DEF,
   parameter int VALUE_WIDTH      = cht_pkg::VALUE_WIDTH_DEF
) (
   input  wire        clock,
   input  wire        reset,
   cht_req_if.sink    req,
   cht_rsp_if.source  rsp
);

   localparam int KeyW    = cht_pkg::KEY_W;
   localparam int BucketW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int EntryW  = 1 + KeyW + VALUE_WIDTH;
   localparam int VldPos  = EntryW - 1;
   localparam int KeyLsb  = VALUE_WIDTH;

   // reciprocal of the bucket count, scaled by 2^31; the estimated
   // quotient is low by at most one, so one subtract corrects it
   localparam logic [31:0]     RecipMul = 32'((64'd1 << 31) / NUM_BUCKETS);
   localparam logic [KeyW-1:0] NumB     = KeyW'(NUM_BUCKETS);
   localparam logic [BucketW-1:0] LastRow = BucketW'(NUM_BUCKETS - 1);

   // sequencer codes
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_RED   = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;

   typedef logic [SLOTS_PER_BUCKET-1:0][EntryW-1:0] row_type;

   // bucket memory: one row holds all slots of a bucket
   row_type mem [NUM_BUCKETS];

   logic [2:0]               state_ff, state_in;
   logic [BucketW-1:0]       clr_ff, clr_in;
   logic [cht_pkg::OP_W-1:0] op_ff;
   logic [KeyW-1:0]          key_ff;
   logic [VALUE_WIDTH-1:0]   wval_ff;
   logic [61:0]              prod_ff;
   logic [KeyW-1:0]          qn_ff;
   logic [BucketW-1:0]       bkt_ff;
   row_type                  rd_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   cht_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [cht_pkg::OUT_VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [KeyW-1:0]             rem;
   logic [KeyW-1:0]             rem_fix;
   logic                        advance;
   logic [SLOTS_PER_BUCKET-1:0] hit_vec, free_vec, hit_oh, free_oh;
   logic [VALUE_WIDTH-1:0]      hit_value;
   row_type                     new_row;
   logic                        is_insert, is_remove;
   logic                        mem_we;
   logic [BucketW-1:0]          mem_waddr;
   row_type                     mem_wdata;

   // the request side is open only between items
   assign req.ready = (state_ff == ST_IDLE);

   // result moves on when the output register is free or being drained
   assign advance = !rsp_valid_ff || rsp.ready;

   // final reduction of key mod bucket count
   assign rem     = key_ff - qn_ff;
   assign rem_fix = (rem >= NumB) ? (rem - NumB) : rem;

   assign is_insert = (op_ff == cht_pkg::OP_INSERT);
   assign is_remove = (op_ff == cht_pkg::OP_REMOVE);

   // parallel compare over the slots of the bucket row
   always_comb begin
      hit_value = '0;
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
         hit_vec[s]  = rd_ff[s][VldPos] && (rd_ff[s][KeyLsb +: KeyW] == key_ff);
         free_vec[s] = !rd_ff[s][VldPos];
      end
      // lowest matching slot and lowest free slot, one-hot
      hit_oh  = hit_vec & (~hit_vec + 1'b1);
      free_oh = free_vec & (~free_vec + 1'b1);
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
         if (hit_oh[s]) begin
            hit_value = hit_value | rd_ff[s][VALUE_WIDTH-1:0];
         end
      end
   end

   // modified row and result of the current request
   always_comb begin
      new_row       = rd_ff;
      mem_we        = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = cht_pkg::STAT_NOT_FOUND;
      priority if (is_insert) begin
         priority if (|hit_vec) begin
            rsp_status_in = cht_pkg::STAT_EXISTS;
         end else if (|free_vec) begin
            rsp_status_in = cht_pkg::STAT_INSERTED;
            mem_we        = 1'b1;
            for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
               if (free_oh[s]) begin
                  new_row[s] = {1'b1, key_ff, wval_ff};
               end
            end
         end else begin
            rsp_status_in = cht_pkg::STAT_FULL;
         end
      end else if (is_remove) begin
         if (|hit_vec) begin
            rsp_status_in = cht_pkg::STAT_REMOVED;
            mem_we        = 1'b1;
            for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
               if (hit_oh[s]) begin
                  new_row[s][VldPos] = 1'b0;
               end
            end
         end else begin
            rsp_status_in = cht_pkg::STAT_REMOVE_ABSENT;
         end
      end else begin
         // find, also taken by the unused op code
         if (|hit_vec) begin
            rsp_status_in = cht_pkg::STAT_FOUND;
            rsp_value_in  = cht_pkg::OUT_VALUE_W'(hit_value);
         end
      end
   end

   // memory write port: clearing pass or write-back of the compared row
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_waddr = bkt_ff;
         mem_wdata = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_CLEAR) || ((state_ff == ST_CMP) && advance && mem_we)) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_RED) begin
         rd_ff <= mem[rem_fix[BucketW-1:0]];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LastRow) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_RED;
         end
         ST_RED: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // hold the read row until the result register frees up
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_CMP) && advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff   <= req.op;
         key_ff  <= req.key;
         wval_ff <= VALUE_WIDTH'(req.write_value);
         // first step of the bucket index: key times scaled reciprocal
         prod_ff <= 62'(62'(req.key) * 62'(RecipMul));
      end
      if (state_ff == ST_MUL) begin
         // estimated quotient times bucket count
         qn_ff <= prod_ff[61:31] * NumB;
      end
      if (state_ff == ST_RED) begin
         bkt_ff <= rem_fix[BucketW-1:0];
      end
      if ((state_ff == ST_CMP) && advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.read_value = rsp_value_ff;

endmodule
`default_nettype wire

[sv/cht_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_checker - port-level checks of the chained hash table
// counts open requests and watches the result channel
// ----------------------------------------------------------------------------
module cht_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_ready,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire [cht_pkg::STATUS_W-1:0]     rsp_status,
   input wire [cht_pkg::OUT_VALUE_W-1:0]  rsp_read_value
);

   logic [1:0] open_ff, open_in;

   always_comb begin
      open_in = open_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         open_in = open_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // the request side is closed right after reset, as the clearing pass begins
   a_clear_closed: assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("request side open right after reset");

   // a result needs an open request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 2'd0))
      else $error("result without a pending request");

   // at most one request in work plus one result waiting
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("too many open requests");

   // value is zero unless the key was found
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != cht_pkg::STAT_FOUND)) |-> (rsp_read_value == '0))
      else $error("nonzero value on a result other than found");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_read_value)))
      else $error("stalled result changed");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_read_value (rsp.read_value)
);
`default_nettype wire
